/* hdl/flt_pkg.sv */
package flt_pkg;

   // store depth default, one entry per buffered character
   localparam int STORE_DEPTH = 64;

   // character codes
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_BLANK = 8'd32;

   // control registers
   localparam int          CFG_W       = 6;
   localparam logic [5:0]  FOLD_RESET  = 6'd10;
   localparam logic [5:0]  TAB_RESET   = 6'd8;
   localparam int          CSR_AW      = 3;
   localparam int          CSR_DW      = 32;
   localparam logic        REG_FOLD    = 1'b0;
   localparam logic        REG_TAB     = 1'b1;

   // result queue
   localparam int OUT_DEPTH = 4;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic [CFG_W-1:0] fold_column;
      logic [CFG_W-1:0] tab_step;
   } cfg_type;

   typedef struct packed {
      logic             done;
      logic [CFG_W-1:0] rem;
   } mod_rsp_type;

   // a tab step of zero behaves as one
   function automatic logic [CFG_W-1:0] tab_eff(input logic [CFG_W-1:0] step);
      tab_eff = (step == '0) ? CFG_W'(1) : step;
   endfunction

endpackage

/* hdl/fold_long_text_lines.sv */
// Line folder with tab expansion. Text bytes enter one beat at a time on the
// req_ channel and are kept in a line memory of STORE_DEPTH entries; folded
// output lines leave on the rsp_ channel, tlast marking the newline that ends
// the bytes one input beat caused (beats that only extend the line give no
// output). The width (register 0, clamped to 2..STORE_DEPTH) and the tab step
// (register 1, zero acts as one) are to be written over the csr_ port only
// while idle; the block itself does not enforce this. An ordinary byte is
// stored directly. A tab passes through the bit-serial remainder unit and then
// stores its blanks, every blank its own memory write, before it closes the
// run. A fold uses the single read port of the line memory to search back for
// a blank, to emit the stored bytes and the newline, and to move the bytes
// after the cut to the front of the line. Emission runs at one byte per cycle
// while the rsp_ side keeps up; a four-beat result queue separates the two
// sides. Bytes left in the line at end of input are not flushed.
module fold_long_text_lines #(
   parameter int STORE_DEPTH = flt_pkg::STORE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] in_char
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] out_char
   output logic                        rsp_tlast,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [flt_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [flt_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [flt_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int TW = flt_pkg::CFG_W;
   localparam int QW = flt_pkg::OUT_CW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TAB_MOD,
      S_TAB_FILL,
      S_SEARCH,
      S_EMIT,
      S_SHIFT
   } state_type;

   flt_pkg::cfg_type     cfg;
   flt_pkg::mod_rsp_type mod_rsp;

   state_type             state_ff, state_in;
   logic [AW-1:0]         col_ff, col_in;
   logic [CW-1:0]         ptr_ff, ptr_in;     // tab fill position
   logic [TW-1:0]         r_ff, r_in;         // ptr modulo tab step
   logic [AW-1:0]         sp_ff, sp_in;       // search read address
   logic [AW-1:0]         chk_ff, chk_in;     // address of read in flight
   logic                  pend_ff, pend_in;   // memory read in flight
   logic [CW-1:0]         len_ff, len_in;     // emit length, also cut point
   logic [CW-1:0]         idx_ff, idx_in;     // emit read index, shift source
   logic [AW-1:0]         dst_ff, dst_in;     // shift destination
   logic                  shift_ff, shift_in;

   logic [6:0]            fold7, w7;
   logic [CW-1:0]         w;
   logic [AW-1:0]         wm1;
   logic [AW-1:0]         pos0;
   logic [TW-1:0]         t_eff;
   logic [7:0]            c;
   logic                  accept;

   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [7:0]            mem_wdata, mem_rdata;
   logic                  mod_start;
   logic                  push, push_last;
   logic [7:0]            push_char;
   logic [flt_pkg::OUT_CW-1:0] q_count;
   logic                  credit;

   function automatic logic [TW-1:0] next_r(input logic [TW-1:0] r,
                                            input logic [TW-1:0] t);
      logic [TW:0] s;
      s = {1'b0, r} + (TW+1)'(1);
      next_r = (s == {1'b0, t}) ? '0 : s[TW-1:0];
   endfunction

   flt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   flt_tab_mod #(.NUM_W(AW)) u_tab_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (pos0),
      .tab_step (cfg.tab_step),
      .rsp      (mod_rsp)
   );

   flt_line_mem #(.DEPTH(STORE_DEPTH), .AW(AW)) u_line_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   flt_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_char  (push_char),
      .push_last  (push_last),
      .count      (q_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // effective width and tab step
   assign fold7 = {1'b0, cfg.fold_column};
   assign w7    = (fold7 < 7'd2) ? 7'd2 :
                  ((fold7 > 7'(STORE_DEPTH)) ? 7'(STORE_DEPTH) : fold7);
   assign w     = CW'(w7);
   assign wm1   = AW'(w - CW'(1));
   assign pos0  = (col_ff >= wm1) ? wm1 : col_ff;
   assign t_eff = flt_pkg::tab_eff(cfg.tab_step);

   assign c          = req_tdata;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   // room in the queue for a read issued now
   assign credit     = (QW'(q_count) + QW'(pend_ff)) < QW'(flt_pkg::OUT_DEPTH);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      ptr_in    = ptr_ff;
      r_in      = r_ff;
      sp_in     = sp_ff;
      chk_in    = chk_ff;
      pend_in   = pend_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      dst_in    = dst_ff;
      shift_in  = shift_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      mod_start = 1'b0;
      push      = 1'b0;
      push_char = '0;
      push_last = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mem_we    = 1'b1;
               mem_waddr = pos0;
               mem_wdata = (c == flt_pkg::CH_TAB) ? flt_pkg::CH_BLANK : c;
               pend_in   = 1'b0;
               idx_in    = '0;
               if (c == flt_pkg::CH_TAB) begin
                  mod_start = 1'b1;
                  ptr_in    = CW'(pos0) + CW'(1);
                  state_in  = S_TAB_MOD;
               end else if (c == flt_pkg::CH_NL) begin
                  if (pos0 == '0) begin
                     col_in = '0;
                  end else begin
                     len_in   = CW'(pos0);
                     shift_in = 1'b0;
                     state_in = S_EMIT;
                  end
               end else if (pos0 == wm1) begin
                  // line full: a blank in the last place or width two folds whole
                  if (c == flt_pkg::CH_BLANK || w == CW'(2)) begin
                     len_in   = w;
                     shift_in = 1'b0;
                     state_in = S_EMIT;
                  end else begin
                     sp_in    = AW'(w - CW'(2));
                     state_in = S_SEARCH;
                  end
               end else begin
                  col_in = pos0 + AW'(1);
               end
            end
         end

         S_TAB_MOD: begin
            if (mod_rsp.done) begin
               r_in     = next_r(mod_rsp.rem, t_eff);
               state_in = S_TAB_FILL;
            end
         end

         // one blank per cycle up to the next stop or the line end
         S_TAB_FILL: begin
            if (ptr_ff >= w) begin
               len_in   = w;
               idx_in   = '0;
               shift_in = 1'b0;
               state_in = S_EMIT;
            end else if (r_ff == '0) begin
               col_in   = AW'(ptr_ff);
               state_in = S_IDLE;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = AW'(ptr_ff);
               mem_wdata = flt_pkg::CH_BLANK;
               ptr_in    = ptr_ff + CW'(1);
               r_in      = next_r(r_ff, t_eff);
            end
         end

         // backward scan for a blank, one read per cycle
         S_SEARCH: begin
            if (pend_ff && mem_rdata == flt_pkg::CH_BLANK) begin
               len_in   = CW'(chk_ff) + CW'(1);
               idx_in   = '0;
               shift_in = 1'b1;
               pend_in  = 1'b0;
               state_in = S_EMIT;
            end else if (pend_ff && chk_ff == AW'(1)) begin
               len_in   = w;
               idx_in   = '0;
               shift_in = 1'b0;
               pend_in  = 1'b0;
               state_in = S_EMIT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = sp_ff;
               pend_in   = 1'b1;
               chk_in    = sp_ff;
               sp_in     = sp_ff - AW'(1);
            end
         end

         // stream stored bytes to the queue, then the newline
         S_EMIT: begin
            if (pend_ff) begin
               push      = 1'b1;
               push_char = mem_rdata;
            end
            if (idx_ff < len_ff && credit) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(idx_ff);
               idx_in    = idx_ff + CW'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (idx_ff == len_ff && !pend_ff &&
                q_count < flt_pkg::OUT_CW'(flt_pkg::OUT_DEPTH)) begin
               push      = 1'b1;
               push_char = flt_pkg::CH_NL;
               push_last = 1'b1;
               if (shift_ff) begin
                  idx_in   = len_ff;
                  dst_in   = '0;
                  state_in = S_SHIFT;
               end else begin
                  col_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end

         // move the tail after the cut to the front of the line
         S_SHIFT: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff;
               mem_wdata = mem_rdata;
               dst_in    = dst_ff + AW'(1);
            end
            if (idx_ff < w) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(idx_ff);
               idx_in    = idx_ff + CW'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  col_in   = dst_ff;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         pend_ff  <= 1'b0;
         shift_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         pend_ff  <= pend_in;
         shift_ff <= shift_in;
      end
      ptr_ff <= ptr_in;
      r_ff   <= r_in;
      sp_ff  <= sp_in;
      chk_ff <= chk_in;
      len_ff <= len_in;
      idx_ff <= idx_in;
      dst_ff <= dst_in;
   end

endmodule

/* hdl/flt_csr.sv */
module flt_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [flt_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [flt_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [flt_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output flt_pkg::cfg_type            cfg
);

   logic [flt_pkg::CFG_W-1:0] fold_ff, fold_in;
   logic [flt_pkg::CFG_W-1:0] tab_ff, tab_in;
   logic                      wr_en;
   logic                      reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // word-aligned decode, byte lane bits ignored
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      fold_in = fold_ff;
      tab_in  = tab_ff;
      if (wr_en) begin
         case (reg_sel)
            flt_pkg::REG_FOLD: fold_in = csr_pwdata[flt_pkg::CFG_W-1:0];
            flt_pkg::REG_TAB:  tab_in  = csr_pwdata[flt_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= flt_pkg::FOLD_RESET;
         tab_ff  <= flt_pkg::TAB_RESET;
      end else begin
         fold_ff <= fold_in;
         tab_ff  <= tab_in;
      end
   end

   // read back
   always_comb begin
      case (reg_sel)
         flt_pkg::REG_FOLD: csr_prdata = flt_pkg::CSR_DW'(fold_ff);
         flt_pkg::REG_TAB:  csr_prdata = flt_pkg::CSR_DW'(tab_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.fold_column = fold_ff;
   assign cfg.tab_step    = tab_ff;

endmodule

/* hdl/flt_tab_mod.sv */
module flt_tab_mod #(
   parameter int NUM_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           dividend,
   input  logic [flt_pkg::CFG_W-1:0]  tab_step,
   output flt_pkg::mod_rsp_type       rsp
);

   // bit-serial restoring remainder, one dividend bit per cycle
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]          num_ff, num_in;
   logic [flt_pkg::CFG_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [flt_pkg::CFG_W-1:0] divisor;
   logic [flt_pkg::CFG_W:0]   sh;

   assign divisor = flt_pkg::tab_eff(tab_step);
   assign sh      = {rem_ff, num_ff[NUM_W-1]};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (sh >= {1'b0, divisor}) begin
            rem_in = flt_pkg::CFG_W'(sh - {1'b0, divisor});
         end else begin
            rem_in = sh[flt_pkg::CFG_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

/* hdl/flt_line_mem.sv */
module flt_line_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/flt_out_fifo.sv */
module flt_out_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [7:0]                  push_char,
   input  logic                        push_last,
   output logic [flt_pkg::OUT_CW-1:0]  count,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast
);

   logic [7:0]                 char_ff [flt_pkg::OUT_DEPTH];
   logic                       last_ff [flt_pkg::OUT_DEPTH];
   logic [flt_pkg::OUT_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [flt_pkg::OUT_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [flt_pkg::OUT_CW-1:0] cnt_ff, cnt_in;
   logic                       pop;

   assign pop = rsp_tvalid & rsp_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + flt_pkg::OUT_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + flt_pkg::OUT_AW'(1);
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + flt_pkg::OUT_CW'(1);
         2'b01:   cnt_in = cnt_ff - flt_pkg::OUT_CW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         char_ff[wr_ptr_ff] <= push_char;
         last_ff[wr_ptr_ff] <= push_last;
      end
   end

   assign count      = cnt_ff;
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = char_ff[rd_ptr_ff];
   assign rsp_tlast  = last_ff[rd_ptr_ff];

endmodule
